FILE: sv/dtl_pkg.sv
// dtl_pkg: shared constants, codes and payload types of the decision tree leaf lookup
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package dtl_pkg;

   // table sizes and walk limit
   localparam int NODE_COUNT    = 1024;
   localparam int FEATURE_COUNT = 256;
   localparam int MAX_DEPTH     = 32;

   // field widths
   localparam int NODE_IDX_W = 10;
   localparam int FEAT_IDX_W = 8;
   localparam int BIN_W      = 8;

   // storage address widths and depth counter width
   localparam int NODE_AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int FEAT_AW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

   // range limits held one bit wider than the index fields
   localparam logic [NODE_IDX_W:0] NODE_LIMIT = (NODE_IDX_W + 1)'(
      (NODE_COUNT > (1 << NODE_IDX_W)) ? (1 << NODE_IDX_W) : NODE_COUNT);
   localparam logic [FEAT_IDX_W:0] FEAT_LIMIT = (FEAT_IDX_W + 1)'(
      (FEATURE_COUNT > (1 << FEAT_IDX_W)) ? (1 << FEAT_IDX_W) : FEATURE_COUNT);

   localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(MAX_DEPTH);

   // action codes
   typedef logic [1:0] action_type;
   localparam action_type ACT_NODE_WR = 2'd0;
   localparam action_type ACT_BIN_WR  = 2'd1;
   localparam action_type ACT_QUERY   = 2'd2;

   // one node table entry (46 bits)
   typedef struct packed {
      logic                  is_leaf;
      logic [FEAT_IDX_W-1:0] feature;
      logic [BIN_W-1:0]      split_bin;
      logic [BIN_W-1:0]      missing_bin;
      logic                  missing_left;
      logic [NODE_IDX_W-1:0] left_node;
      logic [NODE_IDX_W-1:0] right_node;
   } node_entry_type;

   // request transfer
   typedef struct packed {
      action_type            action;
      logic [NODE_IDX_W-1:0] node_index;
      logic                  node_is_leaf;
      logic [FEAT_IDX_W-1:0] node_feature;
      logic [BIN_W-1:0]      node_split_bin;
      logic [BIN_W-1:0]      node_missing_bin;
      logic                  node_missing_left;
      logic [NODE_IDX_W-1:0] node_left_child;
      logic [NODE_IDX_W-1:0] node_right_child;
      logic [FEAT_IDX_W-1:0] feature_index;
      logic [BIN_W-1:0]      feature_bin;
   } req_payload_type;

   // response transfer
   typedef struct packed {
      logic [NODE_IDX_W-1:0] leaf_index;
      logic                  depth_overflow;
   } rsp_payload_type;

   // memory port bundles
   typedef struct packed {
      logic               en;
      logic [NODE_AW-1:0] addr;
      node_entry_type     entry;
   } node_wr_type;

   typedef struct packed {
      logic               en;
      logic [NODE_AW-1:0] addr;
   } node_rd_type;

   typedef struct packed {
      logic               en;
      logic [FEAT_AW-1:0] addr;
      logic [BIN_W-1:0]   data;
   } bin_wr_type;

   typedef struct packed {
      logic               en;
      logic [FEAT_AW-1:0] addr;
   } bin_rd_type;

   // index range checks
   function automatic logic node_in_range(input logic [NODE_IDX_W-1:0] idx);
      return {1'b0, idx} < NODE_LIMIT;
   endfunction

   function automatic logic feat_in_range(input logic [FEAT_IDX_W-1:0] idx);
      return {1'b0, idx} < FEAT_LIMIT;
   endfunction

endpackage

FILE: sv/dtl_node_mem.sv
// dtl_node_mem: node table, one write port and one registered read port
// depends on dtl_pkg
`timescale 1ns / 1ps

module dtl_node_mem
   import dtl_pkg::*;
(
   input  logic           clock,
   input  node_wr_type    node_wr,
   input  node_rd_type    node_rd,
   output node_entry_type node_rd_data
);

   node_entry_type node_array [NODE_COUNT];
   node_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (node_wr.en) begin
         node_array[node_wr.addr] <= node_wr.entry;
      end
   end

   // registered read, data holds while no read is issued
   always_ff @(posedge clock) begin
      if (node_rd.en) begin
         rd_data_ff <= node_array[node_rd.addr];
      end
   end

   assign node_rd_data = rd_data_ff;

endmodule

FILE: sv/dtl_bin_mem.sv
// dtl_bin_mem: per-feature bin codes of the current row, registered read
// depends on dtl_pkg
`timescale 1ns / 1ps

module dtl_bin_mem
   import dtl_pkg::*;
(
   input  logic             clock,
   input  bin_wr_type       bin_wr,
   input  bin_rd_type       bin_rd,
   output logic [BIN_W-1:0] bin_rd_data
);

   logic [BIN_W-1:0] bin_array [FEATURE_COUNT];
   logic [BIN_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (bin_wr.en) begin
         bin_array[bin_wr.addr] <= bin_wr.data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (bin_rd.en) begin
         rd_data_ff <= bin_array[bin_rd.addr];
      end
   end

   assign bin_rd_data = rd_data_ff;

endmodule

FILE: sv/dtl_walker.sv
// dtl_walker: tree walk sequencer with the shared split compare and depth counter
// depends on dtl_pkg; drives the read ports of dtl_node_mem and dtl_bin_mem
`timescale 1ns / 1ps

module dtl_walker
   import dtl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  query_start,
   input  logic [NODE_IDX_W-1:0] start_node,
   output node_rd_type           node_rd,
   input  node_entry_type        node_rd_data,
   output bin_rd_type            bin_rd,
   input  logic [BIN_W-1:0]      bin_rd_data,
   input  logic                  slot_free,
   output logic                  idle,
   output logic                  result_valid,
   output rsp_payload_type       result
);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_NODE = 2'd1;
   localparam logic [1:0] S_BIN  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]            state_ff,   state_in;
   logic [NODE_IDX_W-1:0] cur_ff,     cur_in;
   logic [DEPTH_W-1:0]    depth_ff,   depth_in;
   logic                  ovf_ff,     ovf_in;
   logic                  feat_ok_ff, feat_ok_in;

   logic [BIN_W-1:0]      bin_val;
   logic                  go_left;
   logic [NODE_IDX_W-1:0] next_node;

   // split compare: missing code first, then bin against split
   always_comb begin
      bin_val   = feat_ok_ff ? bin_rd_data : '0;
      if (bin_val == node_rd_data.missing_bin) begin
         go_left = node_rd_data.missing_left;
      end else begin
         go_left = (bin_val <= node_rd_data.split_bin);
      end
      next_node = go_left ? node_rd_data.left_node : node_rd_data.right_node;
   end

   // next state and memory reads
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      depth_in     = depth_ff;
      ovf_in       = ovf_ff;
      feat_ok_in   = feat_ok_ff;
      node_rd.en   = 1'b0;
      node_rd.addr = start_node[NODE_AW-1:0];
      bin_rd.en    = 1'b0;
      bin_rd.addr  = node_rd_data.feature[FEAT_AW-1:0];
      result_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (query_start) begin
               cur_in     = start_node;
               depth_in   = '0;
               ovf_in     = 1'b0;
               node_rd.en = 1'b1;
               state_in   = S_NODE;
            end
         end
         S_NODE: begin
            if (!node_in_range(cur_ff) || node_rd_data.is_leaf) begin
               state_in = S_DONE;
            end else if (depth_ff == DEPTH_LIMIT) begin
               ovf_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               bin_rd.en  = feat_in_range(node_rd_data.feature);
               feat_ok_in = feat_in_range(node_rd_data.feature);
               state_in   = S_BIN;
            end
         end
         S_BIN: begin
            cur_in       = next_node;
            depth_in     = depth_ff + 1'b1;
            node_rd.en   = 1'b1;
            node_rd.addr = next_node[NODE_AW-1:0];
            state_in     = S_NODE;
         end
         S_DONE: begin
            // hold the result until the output register has room
            if (slot_free) begin
               result_valid = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      depth_ff   <= depth_in;
      ovf_ff     <= ovf_in;
      feat_ok_ff <= feat_ok_in;
   end

   assign idle                  = (state_ff == S_IDLE);
   assign result.leaf_index     = cur_ff;
   assign result.depth_overflow = ovf_ff;

endmodule

FILE: sv/decision_tree_leaf_lookup.sv
// decision_tree_leaf_lookup: top level, request decode, table writes and response register
// depends on dtl_pkg, dtl_node_mem, dtl_bin_mem, dtl_walker
//
//   channel  direction  payload           handshake
//   req      in         req_payload_type  req_valid / req_ready
//   rsp      out        rsp_payload_type  rsp_valid / rsp_ready
//
// node and bin writes go into the tables at their transfer; req_ready stays high after them
// a query walks level by level: a node read, then a read of that node's feature bin;
//   a leaf or out-of-range node ends it; the result then waits for a free response slot
// a walk stopped by the depth limit after MAX_DEPTH moves sets depth_overflow
// req_ready is low from a query transfer until its response is registered
// a held response stalls a finished walk, not the writes after it
// reset clears the sequencer and response valid; the tables are not cleared
`timescale 1ns / 1ps

module decision_tree_leaf_lookup
   import dtl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic            req_fire;
   logic            query_start;
   logic            walk_idle;
   logic            slot_free;
   logic            result_valid;
   rsp_payload_type result;

   node_wr_type     node_wr;
   node_rd_type     node_rd;
   node_entry_type  node_rd_data;
   bin_wr_type      bin_wr;
   bin_rd_type      bin_rd;
   logic [BIN_W-1:0] bin_rd_data;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;

   assign req_ready = walk_idle;
   assign req_fire  = req_valid & req_ready;

   // request decode
   always_comb begin
      node_wr.en                 = req_fire && (req_payload.action == ACT_NODE_WR)
                                   && node_in_range(req_payload.node_index);
      node_wr.addr               = req_payload.node_index[NODE_AW-1:0];
      node_wr.entry.is_leaf      = req_payload.node_is_leaf;
      node_wr.entry.feature      = req_payload.node_feature;
      node_wr.entry.split_bin    = req_payload.node_split_bin;
      node_wr.entry.missing_bin  = req_payload.node_missing_bin;
      node_wr.entry.missing_left = req_payload.node_missing_left;
      node_wr.entry.left_node    = req_payload.node_left_child;
      node_wr.entry.right_node   = req_payload.node_right_child;

      bin_wr.en   = req_fire && (req_payload.action == ACT_BIN_WR)
                    && feat_in_range(req_payload.feature_index);
      bin_wr.addr = req_payload.feature_index[FEAT_AW-1:0];
      bin_wr.data = req_payload.feature_bin;

      query_start = req_fire && (req_payload.action == ACT_QUERY);
   end

   dtl_node_mem u_node_mem (
      .clock        (clock),
      .node_wr      (node_wr),
      .node_rd      (node_rd),
      .node_rd_data (node_rd_data)
   );

   dtl_bin_mem u_bin_mem (
      .clock       (clock),
      .bin_wr      (bin_wr),
      .bin_rd      (bin_rd),
      .bin_rd_data (bin_rd_data)
   );

   dtl_walker u_walker (
      .clock        (clock),
      .reset        (reset),
      .query_start  (query_start),
      .start_node   (req_payload.node_index),
      .node_rd      (node_rd),
      .node_rd_data (node_rd_data),
      .bin_rd       (bin_rd),
      .bin_rd_data  (bin_rd_data),
      .slot_free    (slot_free),
      .idle         (walk_idle),
      .result_valid (result_valid),
      .result       (result)
   );

   // response register
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = result_valid || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_valid) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: sv/dtl_checker.sv
// dtl_checker: port-level checks of the decision tree leaf lookup, bound to the top level
// depends on dtl_pkg and decision_tree_leaf_lookup
`timescale 1ns / 1ps

module dtl_checker
   import dtl_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   logic query_xfer;
   logic write_xfer;

   assign query_xfer = req_valid && req_ready && (req_payload.action == ACT_QUERY);
   assign write_xfer = req_valid && req_ready && (req_payload.action != ACT_QUERY);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // a query blocks further requests while it walks
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      query_xfer |=> !req_ready)
      else $error("request accepted during a walk");

   // a write never blocks the next request
   a_write_ready: assert property (@(posedge clock) disable iff (reset)
      write_xfer |=> req_ready)
      else $error("ready dropped after a write");

   // no response can appear the cycle after a query transfer
   a_query_latency: assert property (@(posedge clock) disable iff (reset)
      query_xfer |=> !$rose(rsp_valid))
      else $error("response too early after query");

endmodule

bind decision_tree_leaf_lookup dtl_checker u_dtl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
